FILE: hdl/lrsm_pkg.sv
// Shared types and constants for the letterbox rotate/scale address mapper.
// Holds the field widths, register indexes, reset values and setup states.
// No dependencies; every other file of the block but lrsm_div refers to it by scoped names.
`timescale 1ns / 1ps

package lrsm_pkg;

  // Fixed widths of the channel fields.
  localparam int COORD_W   = 11;
  localparam int IDX_W     = 22;
  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_SRC_WIDTH    = 12'd640;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT   = 12'd480;
  localparam logic [CFG_W-1:0] RST_PANEL_WIDTH  = 12'd720;
  localparam logic [CFG_W-1:0] RST_PANEL_HEIGHT = 12'd1280;

  // Cycles from an accepted start to its result strobe.
  localparam int MAP_LATENCY = 6;

  // Geometry setup sequencer.
  typedef enum logic [3:0] {
    ST_CLAMP,
    ST_PROD,
    ST_ASPECT_GO,
    ST_ASPECT_WAIT,
    ST_FIT,
    ST_OFS,
    ST_RW_GO,
    ST_RW_WAIT,
    ST_RH_GO,
    ST_RH_WAIT,
    ST_READY
  } setup_state_t;

endpackage

FILE: hdl/letterbox_rotate_scale_mapper_unit.sv
// Letterbox rotate/scale mapper, top level. Depends on lrsm_pkg, lrsm_setup, lrsm_map.
// A pixel accepted on start passes through the six map stages to the out_ ports.
// Throughput: one pixel per cycle while busy is low, set by the fully pipelined six-stage map datapath.
// After reset, and after each register write, busy stays high while
// one shared serial divider derives the geometry.
// Reset is synchronous and active low; results cannot be held off by the receiver.
`timescale 1ns / 1ps

module letterbox_rotate_scale_mapper_unit #(
  parameter int MAX_DIM = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Pixel request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [lrsm_pkg::COORD_W-1:0]   in_dest_col,
  input  logic [lrsm_pkg::COORD_W-1:0]   in_dest_row,
  // Result channel, one beat per request
  output logic                           out_valid,
  output logic                           out_in_range,
  output logic [lrsm_pkg::COORD_W-1:0]   out_src_x,
  output logic [lrsm_pkg::COORD_W-1:0]   out_src_y,
  output logic [lrsm_pkg::IDX_W-1:0]     out_src_index,
  output logic [lrsm_pkg::COORD_W-1:0]   out_panel_x,
  output logic [lrsm_pkg::COORD_W-1:0]   out_panel_y,
  output logic [lrsm_pkg::IDX_W-1:0]     out_fb_index,
  // Register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrsm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lrsm_pkg::CFG_W-1:0]     cfg_data
);

  // Dimensions are held saturated to 1..MAX_DIM. A scale numerator is an
  // 11-bit coordinate times a dimension, and the reciprocals are scaled by
  // 2^K with K equal to that numerator width, so a single correction step
  // after the reciprocal multiply gives the exact floor quotient.
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int K      = lrsm_pkg::COORD_W + DIM_W;
  localparam int R_W    = K + 1;
  localparam int NUM_W  = (R_W > 2 * DIM_W) ? R_W : 2 * DIM_W;

  logic             geo_ready;
  logic             take;
  logic [DIM_W-1:0] sw, sh, pw, land_w, dw, dh, ox, oy;
  logic [R_W-1:0]   rw, rh;

  // Register writes are always taken; each one restarts the geometry setup.
  assign cfg_ready = 1'b1;
  // A request is only taken once the geometry for the current registers is final.
  assign busy      = ~geo_ready;
  assign take      = start & geo_ready;

  lrsm_setup #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W),
    .K       (K),
    .NUM_W   (NUM_W),
    .R_W     (R_W)
  ) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ready     (geo_ready),
    .sw        (sw),
    .sh        (sh),
    .pw        (pw),
    .land_w    (land_w),
    .dw        (dw),
    .dh        (dh),
    .ox        (ox),
    .oy        (oy),
    .rw        (rw),
    .rh        (rh)
  );

  // The pixel pipeline carries a valid bit per stage and never stalls.
  lrsm_map #(
    .DIM_W (DIM_W),
    .K     (K),
    .R_W   (R_W)
  ) u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_take       (take),
    .in_dest_col   (in_dest_col),
    .in_dest_row   (in_dest_row),
    .sw            (sw),
    .sh            (sh),
    .pw            (pw),
    .land_w        (land_w),
    .dw            (dw),
    .dh            (dh),
    .ox            (ox),
    .oy            (oy),
    .rw            (rw),
    .rh            (rh),
    .out_valid     (out_valid),
    .out_in_range  (out_in_range),
    .out_src_x     (out_src_x),
    .out_src_y     (out_src_y),
    .out_src_index (out_src_index),
    .out_panel_x   (out_panel_x),
    .out_panel_y   (out_panel_y),
    .out_fb_index  (out_fb_index)
  );

`ifndef SYNTHESIS
  // Every accepted request yields its result beat after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##6 out_valid)
    else $error("result beat missing after accepted request");

  // A result outside the destination carries all-zero fields.
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_src_x == '0 && out_src_y == '0 &&
      out_src_index == '0 && out_panel_x == '0 && out_panel_y == '0 &&
      out_fb_index == '0))
    else $error("out-of-range result with non-zero fields");

  // A register write always forces the geometry to be derived again.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("geometry not recomputed after register write");
`endif

endmodule

FILE: hdl/lrsm_div.sv
// Iterative restoring divider, one quotient bit per clock.
// Used by the geometry setup sequencer; no package dependencies.
`timescale 1ns / 1ps

module lrsm_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // The remainder stays below the divisor, so the trial fits DEN_W+1 bits.
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hdl/lrsm_setup.sv
// Configuration registers and the geometry setup sequencer.
// Depends on lrsm_pkg and on lrsm_div for the aspect and reciprocal divisions.
`timescale 1ns / 1ps

module lrsm_setup #(
  parameter int MAX_DIM = 2048,
  parameter int DIM_W   = 12,
  parameter int K       = 23,
  parameter int NUM_W   = 24,
  parameter int R_W     = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr,
  input  logic [lrsm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lrsm_pkg::CFG_W-1:0]     cfg_data,
  output logic                           ready,
  output logic [DIM_W-1:0]               sw,
  output logic [DIM_W-1:0]               sh,
  output logic [DIM_W-1:0]               pw,
  output logic [DIM_W-1:0]               land_w,
  output logic [DIM_W-1:0]               dw,
  output logic [DIM_W-1:0]               dh,
  output logic [DIM_W-1:0]               ox,
  output logic [DIM_W-1:0]               oy,
  output logic [R_W-1:0]                 rw,
  output logic [R_W-1:0]                 rh
);

  localparam int PR_W = 2 * DIM_W;

  lrsm_pkg::setup_state_t state_r, state_nxt;

  logic [lrsm_pkg::CFG_W-1:0] src_w_cfg_r, src_h_cfg_r, pan_w_cfg_r, pan_h_cfg_r;
  logic [DIM_W-1:0] sw_r, sh_r, pw_r, ph_r;
  logic [PR_W-1:0]  prod_a_r, prod_b_r;
  logic             full_w_r;
  logic             full_w;
  logic [NUM_W-1:0] aq_r;
  logic [DIM_W-1:0] dw_r, dh_r, ox_r, oy_r;
  logic [R_W-1:0]   rw_r, rh_r;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DIM_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [lrsm_pkg::CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v32 > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  function automatic logic [DIM_W-1:0] fit_dim(input logic [NUM_W-1:0] q,
                                              input logic [DIM_W-1:0] lim);
    if (q == '0) begin
      return DIM_W'(1);
    end else if (q > NUM_W'(lim)) begin
      return lim;
    end
    return DIM_W'(q);
  endfunction

  // Configuration registers; any write restarts the geometry sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_cfg_r <= lrsm_pkg::RST_SRC_WIDTH;
      src_h_cfg_r <= lrsm_pkg::RST_SRC_HEIGHT;
      pan_w_cfg_r <= lrsm_pkg::RST_PANEL_WIDTH;
      pan_h_cfg_r <= lrsm_pkg::RST_PANEL_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_index)
        lrsm_pkg::REG_SRC_WIDTH:    src_w_cfg_r <= cfg_data;
        lrsm_pkg::REG_SRC_HEIGHT:   src_h_cfg_r <= cfg_data;
        lrsm_pkg::REG_PANEL_WIDTH:  pan_w_cfg_r <= cfg_data;
        lrsm_pkg::REG_PANEL_HEIGHT: pan_h_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrsm_pkg::ST_CLAMP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign full_w = (prod_a_r <= prod_b_r);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      lrsm_pkg::ST_CLAMP:     state_nxt = lrsm_pkg::ST_PROD;
      lrsm_pkg::ST_PROD:      state_nxt = lrsm_pkg::ST_ASPECT_GO;
      lrsm_pkg::ST_ASPECT_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(full_w ? prod_a_r : prod_b_r);
        div_den   = full_w ? sw_r : sh_r;
        state_nxt = lrsm_pkg::ST_ASPECT_WAIT;
      end
      lrsm_pkg::ST_ASPECT_WAIT: begin
        if (div_done) begin
          state_nxt = lrsm_pkg::ST_FIT;
        end
      end
      lrsm_pkg::ST_FIT:       state_nxt = lrsm_pkg::ST_OFS;
      lrsm_pkg::ST_OFS:       state_nxt = lrsm_pkg::ST_RW_GO;
      lrsm_pkg::ST_RW_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(1) << K;
        div_den   = dw_r;
        state_nxt = lrsm_pkg::ST_RW_WAIT;
      end
      lrsm_pkg::ST_RW_WAIT: begin
        if (div_done) begin
          state_nxt = lrsm_pkg::ST_RH_GO;
        end
      end
      lrsm_pkg::ST_RH_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(1) << K;
        div_den   = dh_r;
        state_nxt = lrsm_pkg::ST_RH_WAIT;
      end
      lrsm_pkg::ST_RH_WAIT: begin
        if (div_done) begin
          state_nxt = lrsm_pkg::ST_READY;
        end
      end
      lrsm_pkg::ST_READY:     state_nxt = lrsm_pkg::ST_READY;
      default:                state_nxt = lrsm_pkg::ST_CLAMP;
    endcase
    if (cfg_wr) begin
      state_nxt = lrsm_pkg::ST_CLAMP;
    end
  end

  // Geometry registers, each group loaded in its own step of the sequence.
  always_ff @(posedge clk) begin
    case (state_r)
      lrsm_pkg::ST_CLAMP: begin
        sw_r <= clamp_dim(src_w_cfg_r);
        sh_r <= clamp_dim(src_h_cfg_r);
        pw_r <= clamp_dim(pan_w_cfg_r);
        ph_r <= clamp_dim(pan_h_cfg_r);
      end
      lrsm_pkg::ST_PROD: begin
        // Landscape width is the panel height and vice versa.
        prod_a_r <= PR_W'(ph_r) * PR_W'(sh_r);
        prod_b_r <= PR_W'(pw_r) * PR_W'(sw_r);
      end
      lrsm_pkg::ST_ASPECT_GO: full_w_r <= full_w;
      lrsm_pkg::ST_ASPECT_WAIT: begin
        if (div_done) begin
          aq_r <= div_quo;
        end
      end
      lrsm_pkg::ST_FIT: begin
        dw_r <= full_w_r ? ph_r : fit_dim(aq_r, ph_r);
        dh_r <= full_w_r ? fit_dim(aq_r, pw_r) : pw_r;
      end
      lrsm_pkg::ST_OFS: begin
        ox_r <= (ph_r - dw_r) >> 1;
        oy_r <= (pw_r - dh_r) >> 1;
      end
      lrsm_pkg::ST_RW_WAIT: begin
        if (div_done) begin
          rw_r <= div_quo[R_W-1:0];
        end
      end
      lrsm_pkg::ST_RH_WAIT: begin
        if (div_done) begin
          rh_r <= div_quo[R_W-1:0];
        end
      end
      default: ;
    endcase
  end

  lrsm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign ready  = (state_r == lrsm_pkg::ST_READY);
  assign sw     = sw_r;
  assign sh     = sh_r;
  assign pw     = pw_r;
  assign land_w = ph_r;
  assign dw     = dw_r;
  assign dh     = dh_r;
  assign ox     = ox_r;
  assign oy     = oy_r;
  assign rw     = rw_r;
  assign rh     = rh_r;

endmodule

FILE: hdl/lrsm_map.sv
// Six-stage per-pixel mapping pipeline: scale by reciprocal, correct, index.
// Depends on lrsm_pkg; user keeps lrsm_setup geometry stable in use, not enforced.
`timescale 1ns / 1ps

module lrsm_map #(
  parameter int DIM_W = 12,
  parameter int K     = 23,
  parameter int R_W   = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_take,
  input  logic [lrsm_pkg::COORD_W-1:0] in_dest_col,
  input  logic [lrsm_pkg::COORD_W-1:0] in_dest_row,
  input  logic [DIM_W-1:0]             sw,
  input  logic [DIM_W-1:0]             sh,
  input  logic [DIM_W-1:0]             pw,
  input  logic [DIM_W-1:0]             land_w,
  input  logic [DIM_W-1:0]             dw,
  input  logic [DIM_W-1:0]             dh,
  input  logic [DIM_W-1:0]             ox,
  input  logic [DIM_W-1:0]             oy,
  input  logic [R_W-1:0]               rw,
  input  logic [R_W-1:0]               rh,
  output logic                         out_valid,
  output logic                         out_in_range,
  output logic [lrsm_pkg::COORD_W-1:0] out_src_x,
  output logic [lrsm_pkg::COORD_W-1:0] out_src_y,
  output logic [lrsm_pkg::IDX_W-1:0]   out_src_index,
  output logic [lrsm_pkg::COORD_W-1:0] out_panel_x,
  output logic [lrsm_pkg::COORD_W-1:0] out_panel_y,
  output logic [lrsm_pkg::IDX_W-1:0]   out_fb_index
);

  localparam int N_W    = lrsm_pkg::COORD_W + DIM_W;
  localparam int PROD_W = N_W + R_W;
  localparam int PR_W   = 2 * DIM_W;
  localparam int RM_W   = (N_W > PR_W) ? N_W : PR_W;
  localparam int CW     = lrsm_pkg::COORD_W;
  localparam int IW     = lrsm_pkg::IDX_W;

  logic [5:0] vld_r;

  // Stage 1
  logic             s1_rng_r;
  logic [N_W-1:0]   s1_nx_r, s1_ny_r;
  logic [DIM_W-1:0] s1_px_r, s1_py_r;
  logic [N_W-1:0]   dx_ext, dy_ext;
  // Stage 2
  logic              s2_rng_r;
  logic [N_W-1:0]    s2_nx_r, s2_ny_r;
  logic [PROD_W-1:0] s2_prx_r, s2_pry_r;
  logic [PR_W-1:0]   s2_fbp_r;
  logic [DIM_W-1:0]  s2_px_r, s2_py_r;
  // Stage 3
  logic             s3_rng_r;
  logic [N_W-1:0]   s3_nx_r, s3_ny_r;
  logic [DIM_W-1:0] s3_qx_r, s3_qy_r;
  logic [PR_W-1:0]  s3_mx_r, s3_my_r;
  logic [IW-1:0]    s3_fb_r;
  logic [DIM_W-1:0] s3_px_r, s3_py_r;
  logic [DIM_W-1:0] q0x, q0y;
  // Stage 4
  logic             s4_rng_r;
  logic [DIM_W-1:0] s4_sx_r, s4_sy_r;
  logic [IW-1:0]    s4_fb_r;
  logic [DIM_W-1:0] s4_px_r, s4_py_r;
  logic [RM_W-1:0]  rx, ry;
  // Stage 5
  logic             s5_rng_r;
  logic [DIM_W-1:0] s5_sx_r, s5_sy_r;
  logic [PR_W-1:0]  s5_ip_r;
  logic [IW-1:0]    s5_fb_r;
  logic [DIM_W-1:0] s5_px_r, s5_py_r;
  // Output stage
  logic             out_in_range_r;
  logic [CW-1:0]    out_src_x_r, out_src_y_r, out_panel_x_r, out_panel_y_r;
  logic [IW-1:0]    out_src_index_r, out_fb_index_r;

  assign dx_ext = N_W'(in_dest_col);
  assign dy_ext = N_W'(in_dest_row);

  // floor(n / d) from n * floor(2^K / d) >> K is low by at most one.
  assign q0x = s2_prx_r[K +: DIM_W];
  assign q0y = s2_pry_r[K +: DIM_W];
  assign rx  = RM_W'(s3_nx_r) - RM_W'(s3_mx_r);
  assign ry  = RM_W'(s3_ny_r) - RM_W'(s3_my_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_take};
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: range test, numerators and panel coordinates.
    s1_rng_r <= (dx_ext < N_W'(dw)) && (dy_ext < N_W'(dh));
    s1_nx_r  <= dx_ext * N_W'(sw);
    s1_ny_r  <= dy_ext * N_W'(sh);
    s1_px_r  <= DIM_W'(N_W'(oy) + dy_ext);
    s1_py_r  <= DIM_W'(N_W'(land_w) - N_W'(ox) - dx_ext - N_W'(1));

    // Stage 2: reciprocal products and frame buffer row product.
    s2_rng_r <= s1_rng_r;
    s2_nx_r  <= s1_nx_r;
    s2_ny_r  <= s1_ny_r;
    s2_prx_r <= PROD_W'(s1_nx_r) * PROD_W'(rw);
    s2_pry_r <= PROD_W'(s1_ny_r) * PROD_W'(rh);
    s2_fbp_r <= PR_W'(s1_py_r) * PR_W'(pw);
    s2_px_r  <= s1_px_r;
    s2_py_r  <= s1_py_r;

    // Stage 3: back-multiply the estimates, finish the frame buffer index.
    s3_rng_r <= s2_rng_r;
    s3_nx_r  <= s2_nx_r;
    s3_ny_r  <= s2_ny_r;
    s3_qx_r  <= q0x;
    s3_qy_r  <= q0y;
    s3_mx_r  <= PR_W'(q0x) * PR_W'(dw);
    s3_my_r  <= PR_W'(q0y) * PR_W'(dh);
    s3_fb_r  <= IW'(PR_W'(s2_fbp_r) + PR_W'(s2_px_r));
    s3_px_r  <= s2_px_r;
    s3_py_r  <= s2_py_r;

    // Stage 4: one correction step on each quotient.
    s4_rng_r <= s3_rng_r;
    s4_sx_r  <= (rx >= RM_W'(dw)) ? s3_qx_r + DIM_W'(1) : s3_qx_r;
    s4_sy_r  <= (ry >= RM_W'(dh)) ? s3_qy_r + DIM_W'(1) : s3_qy_r;
    s4_fb_r  <= s3_fb_r;
    s4_px_r  <= s3_px_r;
    s4_py_r  <= s3_py_r;

    // Stage 5: source row product.
    s5_rng_r <= s4_rng_r;
    s5_sx_r  <= s4_sx_r;
    s5_sy_r  <= s4_sy_r;
    s5_ip_r  <= PR_W'(s4_sy_r) * PR_W'(sw);
    s5_fb_r  <= s4_fb_r;
    s5_px_r  <= s4_px_r;
    s5_py_r  <= s4_py_r;

    // Output stage: source index sum, and zero fields outside the picture.
    out_in_range_r  <= s5_rng_r;
    out_src_x_r     <= s5_rng_r ? CW'(s5_sx_r) : '0;
    out_src_y_r     <= s5_rng_r ? CW'(s5_sy_r) : '0;
    out_src_index_r <= s5_rng_r ? IW'((PR_W + 1)'(s5_ip_r) + (PR_W + 1)'(s5_sx_r)) : '0;
    out_panel_x_r   <= s5_rng_r ? CW'(s5_px_r) : '0;
    out_panel_y_r   <= s5_rng_r ? CW'(s5_py_r) : '0;
    out_fb_index_r  <= s5_rng_r ? s5_fb_r : '0;
  end

  assign out_valid     = vld_r[5];
  assign out_in_range  = out_in_range_r;
  assign out_src_x     = out_src_x_r;
  assign out_src_y     = out_src_y_r;
  assign out_src_index = out_src_index_r;
  assign out_panel_x   = out_panel_x_r;
  assign out_panel_y   = out_panel_y_r;
  assign out_fb_index  = out_fb_index_r;

endmodule

FILE: sim/lrsm_map_checker.sv
// Scoreboard for the letterbox rotate/scale mapper: predicts every mapping and compares.
// Depends on lrsm_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

module lrsm_map_checker #(
  parameter int MAX_DIM = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [lrsm_pkg::COORD_W-1:0]   in_dest_col,
  input  logic [lrsm_pkg::COORD_W-1:0]   in_dest_row,
  input  logic                           out_valid,
  input  logic                           out_in_range,
  input  logic [lrsm_pkg::COORD_W-1:0]   out_src_x,
  input  logic [lrsm_pkg::COORD_W-1:0]   out_src_y,
  input  logic [lrsm_pkg::IDX_W-1:0]     out_src_index,
  input  logic [lrsm_pkg::COORD_W-1:0]   out_panel_x,
  input  logic [lrsm_pkg::COORD_W-1:0]   out_panel_y,
  input  logic [lrsm_pkg::IDX_W-1:0]     out_fb_index,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lrsm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lrsm_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending_count
);

  localparam int COORD_W = lrsm_pkg::COORD_W;
  localparam int IDX_W   = lrsm_pkg::IDX_W;
  localparam int CFG_W   = lrsm_pkg::CFG_W;

  typedef struct packed {
    logic               in_range;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [IDX_W-1:0]   src_index;
    logic [COORD_W-1:0] panel_x;
    logic [COORD_W-1:0] panel_y;
    logic [IDX_W-1:0]   fb_index;
  } map_result_t;

  logic [CFG_W-1:0] src_w_reg;
  logic [CFG_W-1:0] src_h_reg;
  logic [CFG_W-1:0] pan_w_reg;
  logic [CFG_W-1:0] pan_h_reg;

  map_result_t pending_maps[$];
  map_result_t seen_map;
  map_result_t want_map;
  int          mismatches = 0;

  assign seen_map = {out_in_range, out_src_x, out_src_y, out_src_index,
                     out_panel_x, out_panel_y, out_fb_index};

  // Zero reads as one and anything beyond the largest dimension saturates.
  function automatic int unsigned saturate_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic map_result_t predict_mapping(input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] row);
    int unsigned sw, sh, land_w, land_h, dw, dh, ox, oy, sx, sy, px, py;
    map_result_t r;
    sw     = saturate_dim(src_w_reg);
    sh     = saturate_dim(src_h_reg);
    land_h = saturate_dim(pan_w_reg);
    land_w = saturate_dim(pan_h_reg);
    // Fit whichever landscape dimension is the tighter one.
    if (land_w * sh <= land_h * sw) begin
      dw = land_w;
      dh = land_w * sh / sw;
    end else begin
      dh = land_h;
      dw = land_h * sw / sh;
    end
    if (dw < 1) dw = 1;
    if (dh < 1) dh = 1;
    if (dw > land_w) dw = land_w;
    if (dh > land_h) dh = land_h;
    ox = (land_w - dw) / 2;
    oy = (land_h - dh) / 2;
    r  = '0;
    if (col >= dw || row >= dh) return r;
    sx = col * sw / dw;
    sy = row * sh / dh;
    px = oy + row;
    py = land_w - 1 - (ox + col);
    r.in_range  = 1'b1;
    r.src_x     = COORD_W'(sx);
    r.src_y     = COORD_W'(sy);
    r.src_index = IDX_W'(sy * sw + sx);
    r.panel_x   = COORD_W'(px);
    r.panel_y   = COORD_W'(py);
    r.fb_index  = IDX_W'(py * land_h + px);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_w_reg = lrsm_pkg::RST_SRC_WIDTH;
      src_h_reg = lrsm_pkg::RST_SRC_HEIGHT;
      pan_w_reg = lrsm_pkg::RST_PANEL_WIDTH;
      pan_h_reg = lrsm_pkg::RST_PANEL_HEIGHT;
      pending_maps.delete();
    end else begin
      if (out_valid) begin
        if (pending_maps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing expected: %p", seen_map);
        end else begin
          want_map = pending_maps.pop_front();
          if (seen_map !== want_map) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mapping differs (expected/actual): in_range %0d/%0d src_x %0d/%0d",
                       want_map.in_range, seen_map.in_range, want_map.src_x, seen_map.src_x,
                       " src_y %0d/%0d src_index %0d/%0d",
                       want_map.src_y, seen_map.src_y, want_map.src_index, seen_map.src_index,
                       " panel_x %0d/%0d panel_y %0d/%0d fb_index %0d/%0d",
                       want_map.panel_x, seen_map.panel_x, want_map.panel_y,
                       seen_map.panel_y, want_map.fb_index, seen_map.fb_index);
            end
          end
        end
      end
      if (start && !busy) pending_maps.push_back(predict_mapping(in_dest_col, in_dest_row));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lrsm_pkg::REG_SRC_WIDTH: begin
            src_w_reg = cfg_data;
          end
          lrsm_pkg::REG_SRC_HEIGHT: begin
            src_h_reg = cfg_data;
          end
          lrsm_pkg::REG_PANEL_WIDTH: begin
            pan_w_reg = cfg_data;
          end
          lrsm_pkg::REG_PANEL_HEIGHT: begin
            pan_h_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_maps.size();
  end

endmodule

FILE: sim/letterbox_rotate_scale_mapper_unit_tb.sv
// Stimulus and verdict for the letterbox rotate/scale mapper top level.
// Depends on lrsm_pkg, the mapper RTL and lrsm_map_checker, which does all the result checking.
`timescale 1ns / 1ps

module letterbox_rotate_scale_mapper_unit_tb;

  localparam int COORD_W   = lrsm_pkg::COORD_W;
  localparam int IDX_W     = lrsm_pkg::IDX_W;
  localparam int CFG_W     = lrsm_pkg::CFG_W;
  localparam int REG_IDX_W = lrsm_pkg::REG_IDX_W;

  // Roughly how many pixel beats to send, and how many of them go at full rate at the end.
  localparam int ITEM_TARGET = 1450;
  localparam int CALM_ITEMS  = 150;
  // The limit lies many times above the length of the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic [COORD_W-1:0]   in_dest_col = '0;
  logic [COORD_W-1:0]   in_dest_row = '0;
  logic                 cfg_valid   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;

  logic                 busy;
  logic                 out_valid;
  logic                 out_in_range;
  logic [COORD_W-1:0]   out_src_x;
  logic [COORD_W-1:0]   out_src_y;
  logic [IDX_W-1:0]     out_src_index;
  logic [COORD_W-1:0]   out_panel_x;
  logic [COORD_W-1:0]   out_panel_y;
  logic [IDX_W-1:0]     out_fb_index;
  logic                 cfg_ready;

  int fail_count;
  int pending_count;

  int          items_sent  = 0;
  int          cycle_count = 0;
  bit          gaps_on     = 1'b1;
  // Upper bounds for aimed coordinates: the landscape size, so that the edge of the
  // destination and the region just past it are both hit often.
  int unsigned aim_w;
  int unsigned aim_h;

  // Probe points for the reset geometry (960 x 720 destination, centred 160 across).
  int unsigned reset_probes[12][2] = '{
    '{0, 0}, '{2047, 2047}, '{2047, 0}, '{0, 2047}, '{959, 719}, '{960, 719},
    '{959, 720}, '{960, 0}, '{0, 720}, '{480, 360}, '{1, 1}, '{1279, 719}
  };

  letterbox_rotate_scale_mapper_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_dest_col   (in_dest_col),
    .in_dest_row   (in_dest_row),
    .out_valid     (out_valid),
    .out_in_range  (out_in_range),
    .out_src_x     (out_src_x),
    .out_src_y     (out_src_y),
    .out_src_index (out_src_index),
    .out_panel_x   (out_panel_x),
    .out_panel_y   (out_panel_y),
    .out_fb_index  (out_fb_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lrsm_map_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_dest_col   (in_dest_col),
    .in_dest_row   (in_dest_row),
    .out_valid     (out_valid),
    .out_in_range  (out_in_range),
    .out_src_x     (out_src_x),
    .out_src_y     (out_src_y),
    .out_src_index (out_src_index),
    .out_panel_x   (out_panel_x),
    .out_panel_y   (out_panel_y),
    .out_fb_index  (out_fb_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("letterbox_rotate_scale_mapper_unit: mismatch");
      $finish;
    end
  end

  // Length of an idle burst ahead of a beat: none most of the time, otherwise drawn at random,
  // and never once the full-rate tail of the run has begun.
  function automatic int unsigned burst_len();
    if (!gaps_on || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  // Largest coordinate worth aiming at for a register value, after the block's own
  // treatment of zero, capped at what an 11-bit coordinate can hold.
  function automatic int unsigned aim_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > 2047) return 2047;
    return 32'(v);
  endfunction

  // Mostly small pictures and panels, so that every pixel near the edges of the
  // destination is likely to be probed, with some large, zero and saturating values.
  function automatic logic [CFG_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 4) return CFG_W'($urandom_range(1, 40));
    if (pick <= 7) return CFG_W'($urandom_range(1, 2048));
    if (pick == 8) begin
      case ($urandom_range(0, 2))
        0: begin
          return '0;
        end
        1: begin
          return '1;
        end
        default: begin
          return CFG_W'($urandom_range(2049, 4095));
        end
      endcase
    end
    return CFG_W'($urandom_range(0, 4095));
  endfunction

  // One register beat. The valid stays high into the next write when there is no gap;
  // the caller lowers it after the last one.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int unsigned gap;
    gap = burst_len();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes the whole geometry. Only called when no result is outstanding.
  task automatic configure(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                           input logic [CFG_W-1:0] pw, input logic [CFG_W-1:0] ph);
    write_reg(lrsm_pkg::REG_SRC_WIDTH, sw);
    write_reg(lrsm_pkg::REG_SRC_HEIGHT, sh);
    write_reg(lrsm_pkg::REG_PANEL_WIDTH, pw);
    write_reg(lrsm_pkg::REG_PANEL_HEIGHT, ph);
    cfg_valid <= 1'b0;
    aim_w = aim_dim(ph);
    aim_h = aim_dim(pw);
  endtask

  // One pixel beat: start is held until an edge sees busy low. As with the register
  // channel, start stays high into the next beat unless a gap is taken.
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int unsigned gap;
    gap = burst_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_dest_col <= col;
    in_dest_row <= row;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Most requests are aimed at the landscape area; the rest cover the full 11-bit range
  // so that every coordinate bit toggles, whatever the geometry.
  task automatic random_pixel();
    if ($urandom_range(0, 6) == 0) begin
      send_pixel(COORD_W'($urandom_range(0, 2047)), COORD_W'($urandom_range(0, 2047)));
    end else begin
      send_pixel(COORD_W'($urandom_range(0, aim_w)), COORD_W'($urandom_range(0, aim_h)));
    end
  endtask

  // Lets the pipeline empty before the geometry changes, and again at the end.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (lrsm_pkg::MAP_LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    aim_w = aim_dim(lrsm_pkg::RST_PANEL_HEIGHT);
    aim_h = aim_dim(lrsm_pkg::RST_PANEL_WIDTH);

    // Reset geometry: the full-height branch of the fit, probed at the corners and on
    // both sides of the destination's edges.
    foreach (reset_probes[i]) begin
      send_pixel(COORD_W'(reset_probes[i][0]), COORD_W'(reset_probes[i][1]));
    end
    drain();

    // All registers zero: everything collapses to a single pixel.
    configure('0, '0, '0, '0);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(2047, 2047);
    drain();

    // All registers at their largest value, which saturates to the largest dimension.
    configure('1, '1, '1, '1);
    send_pixel(2047, 2047);
    send_pixel(0, 0);
    send_pixel(1024, 1024);
    drain();

    // Exact aspect tie with a one-pixel-wide landscape, then the transposed case.
    configure(12'd1, 12'd2048, 12'd2048, 12'd1);
    send_pixel(0, 2047);
    send_pixel(1, 0);
    drain();
    configure(12'd2048, 12'd1, 12'd1, 12'd2048);
    send_pixel(2047, 0);
    send_pixel(0, 1);
    drain();

    // Random geometries, each followed by a burst of requests.
    while (items_sent < ITEM_TARGET - CALM_ITEMS) begin
      configure(random_dim(), random_dim(), random_dim(), random_dim());
      repeat ($urandom_range(40, 120)) random_pixel();
      drain();
    end

    // Last stretch back to back, one beat per cycle once busy is low.
    gaps_on = 1'b0;
    configure(random_dim(), random_dim(), random_dim(), random_dim());
    repeat (CALM_ITEMS) random_pixel();
    drain();

    if (fail_count == 0 && pending_count == 0) begin
      $display("letterbox_rotate_scale_mapper_unit: match");
    end else begin
      $display("letterbox_rotate_scale_mapper_unit: mismatch");
    end
    $finish;
  end

endmodule
